### sv/keypad_debounce_autorepeat_macros.svh
// Assertion macros shared by the keypad debounce and auto-repeat design.
`ifndef KEYPAD_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define KEYPAD_DEBOUNCE_AUTOREPEAT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define KDA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keypad debounce assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define KDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keypad debounce assertion failed");

`endif

### sv/kda_pkg.sv
// Package with sizes, reset values and register indexes of the keypad debouncer.
package kda_pkg;

   localparam int KEYS = 4;
   localparam int TIMER_BITS = 16;
   localparam int DEBOUNCE_BITS = 7;
   localparam int INTERVAL_BITS = 16;
   localparam int MULT_BITS = 2;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int CMP_BITS = (TIMER_BITS > INTERVAL_BITS) ? TIMER_BITS : INTERVAL_BITS;

   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 7'd50;
   localparam logic [INTERVAL_BITS-1:0] PRE_REPEAT_RESET = 16'd1000;
   localparam logic [INTERVAL_BITS-1:0] REPEAT_RESET = 16'd200;
   localparam logic [INTERVAL_BITS-1:0] MULTIPLY_RESET = 16'd3000;
   localparam logic [MULT_BITS-1:0] MULT_MAX = 2'd3;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_DEBOUNCE   = 2'd0,
      CSR_PRE_REPEAT = 2'd1,
      CSR_REPEAT     = 2'd2,
      CSR_MULTIPLY   = 2'd3
   } csr_index_type;

   typedef logic [DEBOUNCE_BITS-1:0] count_type;
   typedef logic [TIMER_BITS-1:0] timer_type;

endpackage

### sv/keypad_debounce_autorepeat.sv
// Keypad debouncer with auto-repeat and hold multiplier, one tick item per cycle at most.
// The result of a tick item is valid in the cycle after it is accepted.
// Input stalls while a result waits; the result register frees itself when taken.
// The whole tick update is one pass of logic from the input port to the state and result.
// Synchronous reset clears the key state, timers, multiplier and result valid flag,
// and loads the interval registers with their default values.
`include "keypad_debounce_autorepeat_macros.svh"

module keypad_debounce_autorepeat
   import kda_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [KEYS-1:0]          req_keys_raw,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [KEYS-1:0]          rsp_one_shot,
   output logic [KEYS-1:0]          rsp_keys_pressed,
   output logic [MULT_BITS-1:0]     rsp_multiplier,
   input  logic                     csr_wen,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic [DEBOUNCE_BITS-1:0] debounce_ms_ff;
   logic [INTERVAL_BITS-1:0] pre_repeat_ms_ff;
   logic [INTERVAL_BITS-1:0] repeat_ms_ff;
   logic [INTERVAL_BITS-1:0] multiply_ms_ff;

   count_type             count_ff [KEYS];
   count_type             count_in [KEYS];
   logic [KEYS-1:0]       pressed_ff, pressed_in;
   logic [KEYS-1:0]       was_pressed_ff, was_pressed_in;
   timer_type             repeat_ff, repeat_in;
   timer_type             prerepeat_ff, prerepeat_in;
   timer_type             multiply_ff, multiply_in;
   logic [MULT_BITS-1:0]  mult_ff, mult_in;
   logic [KEYS-1:0]       shot_in;

   logic                  rsp_valid_ff;
   logic [KEYS-1:0]       rsp_one_shot_ff;
   logic [KEYS-1:0]       rsp_keys_pressed_ff;
   logic [MULT_BITS-1:0]  rsp_multiplier_ff;

   logic                  accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_one_shot = rsp_one_shot_ff;
   assign rsp_keys_pressed = rsp_keys_pressed_ff;
   assign rsp_multiplier = rsp_multiplier_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DEBOUNCE_RESET;
         pre_repeat_ms_ff <= PRE_REPEAT_RESET;
         repeat_ms_ff <= REPEAT_RESET;
         multiply_ms_ff <= MULTIPLY_RESET;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_addr))
            CSR_DEBOUNCE: begin
               debounce_ms_ff <= csr_wdata[DEBOUNCE_BITS-1:0];
            end
            CSR_PRE_REPEAT: begin
               pre_repeat_ms_ff <= csr_wdata[INTERVAL_BITS-1:0];
            end
            CSR_REPEAT: begin
               repeat_ms_ff <= csr_wdata[INTERVAL_BITS-1:0];
            end
            CSR_MULTIPLY: begin
               multiply_ms_ff <= csr_wdata[INTERVAL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      pressed_in = pressed_ff;
      for (int i = 0; i < KEYS; i++) begin
         count_in[i] = count_ff[i];
         if (!req_keys_raw[i] && (count_ff[i] < debounce_ms_ff)) begin
            count_in[i] = count_ff[i] + 1'b1;
         end
         if (req_keys_raw[i] && (count_ff[i] != '0)) begin
            count_in[i] = count_ff[i] - 1'b1;
         end
         if (count_in[i] == '0) begin
            pressed_in[i] = 1'b0;
         end
         if (count_in[i] == debounce_ms_ff) begin
            pressed_in[i] = 1'b1;
         end
      end

      shot_in = pressed_in & ~was_pressed_ff;
      was_pressed_in = pressed_in;

      repeat_in = (repeat_ff == '1) ? repeat_ff : repeat_ff + 1'b1;
      prerepeat_in = (prerepeat_ff == '1) ? prerepeat_ff : prerepeat_ff + 1'b1;
      multiply_in = (multiply_ff == '1) ? multiply_ff : multiply_ff + 1'b1;
      mult_in = mult_ff;

      if (pressed_in == '0) begin
         mult_in = '0;
         repeat_in = '0;
         prerepeat_in = '0;
         multiply_in = '0;
      end

      // Auto-repeat clears the edge history so the held keys fire on the next tick.
      if ((CMP_BITS'(prerepeat_in) >= CMP_BITS'(pre_repeat_ms_ff)) &&
          (CMP_BITS'(repeat_in) >= CMP_BITS'(repeat_ms_ff))) begin
         was_pressed_in = '0;
         repeat_in = '0;
      end

      if (CMP_BITS'(multiply_in) >= CMP_BITS'(multiply_ms_ff)) begin
         multiply_in = '0;
         if (mult_in != MULT_MAX) begin
            mult_in = mult_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEYS; i++) begin
            count_ff[i] <= '0;
         end
         pressed_ff <= '0;
         was_pressed_ff <= '0;
         repeat_ff <= '0;
         prerepeat_ff <= '0;
         multiply_ff <= '0;
         mult_ff <= '0;
      end else if (accept) begin
         for (int i = 0; i < KEYS; i++) begin
            count_ff[i] <= count_in[i];
         end
         pressed_ff <= pressed_in;
         was_pressed_ff <= was_pressed_in;
         repeat_ff <= repeat_in;
         prerepeat_ff <= prerepeat_in;
         multiply_ff <= multiply_in;
         mult_ff <= mult_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_one_shot_ff <= shot_in;
         rsp_keys_pressed_ff <= pressed_in;
         rsp_multiplier_ff <= mult_in;
      end
   end

   `KDA_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff)
   `KDA_ASSERT_SAME(a_shot_only_when_pressed, clock, reset, rsp_valid_ff, (rsp_one_shot_ff & ~rsp_keys_pressed_ff) == '0)
   `KDA_ASSERT_SAME(a_idle_timers_clear, clock, reset, pressed_ff == '0, (repeat_ff == '0) && (prerepeat_ff == '0) && (multiply_ff == '0))

endmodule
